>>> rtl/core/bwm_pkg.sv
// Shared types and constants for the breakpoint and watchpoint matcher.
package bwm_pkg;

	// Request codes carried on the action field
	typedef enum logic [2:0] {
		ACT_ADD_ADDR = 3'd0,
		ACT_ADD_OP   = 3'd1,
		ACT_ADD_MEM  = 3'd2,
		ACT_CHK_ADDR = 3'd3,
		ACT_CHK_OP   = 3'd4,
		ACT_CHK_MEM  = 3'd5
	} action_t;

	// Hit kind codes; also used to name which table a scan walks
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_ADDR = 2'd1,
		KIND_OP   = 2'd2,
		KIND_MEM  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	// Widest table entry: watchpoint {value, value_valid, write, read, address}
	localparam int unsigned ADDR_W  = 16;
	localparam int unsigned DATA_W  = 8;
	localparam int unsigned ENTRY_W = ADDR_W + 3 + DATA_W;

endpackage

>>> rtl/core/breakpoint_watchpoint_matcher.sv
// Breakpoint and watchpoint matcher: one shared table memory and a scan sequencer.
//
//   channel  direction  handshake             payload
//   -------  ---------  --------------------  ------------------------------------------
//   in       input      in_valid / in_ready   action, address, opcode, cb_prefix,
//                                             is_read, is_write, value_valid, data_value
//   out      output     out_valid / out_ready hit, hit_kind, table_full
//
// An add request is accepted and its result registered in the idle state, then
// moved to the output register. A check request scans the entries in use in its
// table, one memory read per entry through the single read port.
// One request is in flight at a time; in_ready is high only in the idle state.
// The result sits in an output register, so a new request may be accepted
// while the previous result still waits for out_ready.
// Reset clears the entry counts and control state; table contents are not
// cleared, since only entries below a count are ever read.
module breakpoint_watchpoint_matcher #(
	parameter int unsigned ADDR_SLOTS  = 16,
	parameter int unsigned OP_SLOTS    = 16,
	parameter int unsigned WATCH_SLOTS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  action,
	input  logic [bwm_pkg::ADDR_W-1:0]  address,
	input  logic [7:0]                  opcode,
	input  logic                        cb_prefix,
	input  logic                        is_read,
	input  logic                        is_write,
	input  logic                        value_valid,
	input  logic [bwm_pkg::DATA_W-1:0]  data_value,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        hit,
	output logic [1:0]                  hit_kind,
	output logic                        table_full
);
	import bwm_pkg::*;

	// All three tables share one memory, laid out back to back
	localparam int unsigned TOTAL  = ADDR_SLOTS + OP_SLOTS + WATCH_SLOTS;
	localparam int unsigned MEM_AW = $clog2(TOTAL);
	localparam int unsigned ACW    = $clog2(ADDR_SLOTS + 1);
	localparam int unsigned OCW    = $clog2(OP_SLOTS + 1);
	localparam int unsigned WCW    = $clog2(WATCH_SLOTS + 1);

	localparam logic [MEM_AW-1:0] ADDR_BASE  = '0;
	localparam logic [MEM_AW-1:0] OP_BASE    = MEM_AW'(ADDR_SLOTS);
	localparam logic [MEM_AW-1:0] WATCH_BASE = MEM_AW'(ADDR_SLOTS + OP_SLOTS);

	localparam logic [ACW-1:0] ADDR_FULL  = ACW'(ADDR_SLOTS);
	localparam logic [OCW-1:0] OP_FULL    = OCW'(OP_SLOTS);
	localparam logic [WCW-1:0] WATCH_FULL = WCW'(WATCH_SLOTS);

	// table storage, single write port, single registered read port
	logic [ENTRY_W-1:0] mem [TOTAL];

	state_t state_q, state_d;

	logic [ACW-1:0] addr_cnt_q;
	logic [OCW-1:0] op_cnt_q;
	logic [WCW-1:0] watch_cnt_q;

	// latched check request
	kind_t               req_kind_q;
	logic [ADDR_W-1:0]   req_addr_q;
	logic [8:0]          req_op_q;
	logic                req_rd_q;
	logic                req_wr_q;
	logic                req_vv_q;
	logic [DATA_W-1:0]   req_val_q;

	// scan sequencer
	logic [MEM_AW-1:0]   base_q;
	logic [MEM_AW-1:0]   idx_q;
	logic [MEM_AW:0]     scan_cnt_q;
	logic                hit_acc_q;
	logic                rd_vld_s1;
	logic [ENTRY_W-1:0]  rd_data_s1;

	// finished result waiting for the output register
	logic                res_hit_q;
	kind_t               res_kind_q;
	logic                res_full_q;

	// output register
	logic                out_valid_q;
	logic                hit_q;
	kind_t               hit_kind_q;
	logic                table_full_q;

	// control from the state machine
	logic                mem_we;
	logic [MEM_AW-1:0]   mem_waddr;
	logic [ENTRY_W-1:0]  mem_wdata;
	logic                addr_inc, op_inc, watch_inc;
	logic                scan_start;
	kind_t               scan_kind;
	logic [MEM_AW-1:0]   scan_base;
	logic [MEM_AW:0]     scan_cnt;
	logic                issue;
	logic [MEM_AW-1:0]   rd_addr;
	logic                res_load;
	logic                res_hit;
	kind_t               res_kind;
	logic                res_full;
	logic                out_load;
	logic                entry_match;
	logic                last_issue;

	// compare of the entry read last cycle against the latched request
	always_comb begin
		logic w_addr_eq, w_dir, w_val_ok;
		w_addr_eq = rd_data_s1[ADDR_W-1:0] == req_addr_q;
		w_dir = (req_rd_q & rd_data_s1[ADDR_W]) | (req_wr_q & rd_data_s1[ADDR_W+1]);
		w_val_ok = !(req_vv_q & rd_data_s1[ADDR_W+2]) ||
			(rd_data_s1[ENTRY_W-1 -: DATA_W] == req_val_q);
		unique case (req_kind_q)
			KIND_ADDR: entry_match = w_addr_eq;
			KIND_OP:   entry_match = rd_data_s1[8:0] == req_op_q;
			KIND_MEM:  entry_match = w_addr_eq & w_dir & w_val_ok;
			default:   entry_match = 1'b0;
		endcase
	end

	assign rd_addr    = base_q + idx_q;
	assign last_issue = ((MEM_AW+1)'(idx_q) + 1'b1) == scan_cnt_q;

	// next state and control
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = '0;
		addr_inc   = 1'b0;
		op_inc     = 1'b0;
		watch_inc  = 1'b0;
		scan_start = 1'b0;
		scan_kind  = KIND_NONE;
		scan_base  = ADDR_BASE;
		scan_cnt   = '0;
		issue      = 1'b0;
		res_load   = 1'b0;
		res_hit    = 1'b0;
		res_kind   = KIND_NONE;
		res_full   = 1'b0;
		out_load   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					res_load = 1'b1;
					state_d  = ST_RESULT;
					unique case (action_t'(action))
						ACT_ADD_ADDR: begin
							if (addr_cnt_q != ADDR_FULL) begin
								mem_we    = 1'b1;
								mem_waddr = ADDR_BASE + MEM_AW'(addr_cnt_q);
								mem_wdata = ENTRY_W'(address);
								addr_inc  = 1'b1;
							end else begin
								res_full = 1'b1;
							end
						end
						ACT_ADD_OP: begin
							if (op_cnt_q != OP_FULL) begin
								mem_we    = 1'b1;
								mem_waddr = OP_BASE + MEM_AW'(op_cnt_q);
								mem_wdata = ENTRY_W'({cb_prefix, opcode});
								op_inc    = 1'b1;
							end else begin
								res_full = 1'b1;
							end
						end
						ACT_ADD_MEM: begin
							if (watch_cnt_q != WATCH_FULL) begin
								mem_we    = 1'b1;
								mem_waddr = WATCH_BASE + MEM_AW'(watch_cnt_q);
								mem_wdata = {data_value, value_valid, is_write, is_read, address};
								watch_inc = 1'b1;
							end else begin
								res_full = 1'b1;
							end
						end
						ACT_CHK_ADDR: begin
							scan_kind = KIND_ADDR;
							scan_base = ADDR_BASE;
							scan_cnt  = (MEM_AW+1)'(addr_cnt_q);
						end
						ACT_CHK_OP: begin
							scan_kind = KIND_OP;
							scan_base = OP_BASE;
							scan_cnt  = (MEM_AW+1)'(op_cnt_q);
						end
						ACT_CHK_MEM: begin
							scan_kind = KIND_MEM;
							scan_base = WATCH_BASE;
							scan_cnt  = (MEM_AW+1)'(watch_cnt_q);
						end
						default: ;
					endcase
					// a check against an empty table reports a miss at once
					if (scan_kind != KIND_NONE && scan_cnt != '0) begin
						res_load   = 1'b0;
						scan_start = 1'b1;
						state_d    = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				issue = 1'b1;
				if (last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last entry's data is in rd_data_s1 this cycle
				res_load = 1'b1;
				res_hit  = hit_acc_q | entry_match;
				res_kind = res_hit ? req_kind_q : KIND_NONE;
				state_d  = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Writes happen only in idle and reads only while scanning, so the
	// state machine keeps the two ports from touching the same entry at once.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// entry counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_cnt_q  <= '0;
			op_cnt_q    <= '0;
			watch_cnt_q <= '0;
		end else begin
			if (addr_inc)  addr_cnt_q  <= addr_cnt_q + 1'b1;
			if (op_inc)    op_cnt_q    <= op_cnt_q + 1'b1;
			if (watch_inc) watch_cnt_q <= watch_cnt_q + 1'b1;
		end
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			idx_q      <= '0;
			hit_acc_q  <= 1'b0;
			req_kind_q <= KIND_NONE;
		end else begin
			rd_vld_s1 <= issue;
			if (scan_start) begin
				idx_q      <= '0;
				hit_acc_q  <= 1'b0;
				req_kind_q <= scan_kind;
			end else begin
				if (issue) idx_q <= idx_q + 1'b1;
				if (rd_vld_s1 && entry_match) hit_acc_q <= 1'b1;
			end
		end
	end

	// request payload for the scan, the finished result and the output register
	always_ff @(posedge clk) begin
		if (scan_start) begin
			base_q     <= scan_base;
			scan_cnt_q <= scan_cnt;
			req_addr_q <= address;
			req_op_q   <= {cb_prefix, opcode};
			req_rd_q   <= is_read;
			req_wr_q   <= is_write;
			req_vv_q   <= value_valid;
			req_val_q  <= data_value;
		end
		if (res_load) begin
			res_hit_q  <= res_hit;
			res_kind_q <= res_kind;
			res_full_q <= res_full;
		end
		if (out_load) begin
			hit_q        <= res_hit_q;
			hit_kind_q   <= res_kind_q;
			table_full_q <= res_full_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign hit_kind   = hit_kind_q;
	assign table_full = table_full_q;

endmodule

>>> rtl/core/bwm_checker.sv
// Port-level checks for the breakpoint and watchpoint matcher, bound to the top level.
module bwm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        hit,
	input logic [1:0]                  hit_kind,
	input logic                        table_full
);
	import bwm_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(hit_kind)
			&& $stable(table_full))
		else $error("result changed while stalled");

	// one request at a time: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request accepted while busy");

	// hit and kind agree
	a_kind_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit == (hit_kind != KIND_NONE)))
		else $error("hit and hit_kind disagree");

	// a dropped add never reports a hit
	a_full_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> !hit)
		else $error("table_full together with hit");

endmodule

bind breakpoint_watchpoint_matcher bwm_checker u_bwm_checker (.*);

>>> test/tb_breakpoint_watchpoint_matcher.sv
// Self-checking testbench for the breakpoint and watchpoint matcher.
module tb_breakpoint_watchpoint_matcher;
	import bwm_pkg::*;

	// Action codes the block leaves unused; they must produce an all-zero result
	localparam logic [2:0] ACT_RSVD6 = 3'd6;
	localparam logic [2:0] ACT_RSVD7 = 3'd7;

	localparam int ADDR_SLOTS  = 16;
	localparam int OP_SLOTS    = 16;
	localparam int WATCH_SLOTS = 16;

	// Handshake pressure modes
	localparam int MODE_STEADY      = 0;
	localparam int MODE_SEND_GAPS   = 1;
	localparam int MODE_RECV_STALLS = 2;
	localparam int MODE_BOTH        = 3;
	localparam int MODE_COUNT       = 4;

	localparam int REQS_PER_MODE = 258;
	// Covers the longest check, a full table of 16 entries, with a little margin on top
	localparam int DRAIN_CYCLES  = 24;

	localparam logic TYPED   = 1'b1;
	localparam logic PREDICT = 1'b0;

	typedef struct packed {
		logic [2:0]  act;
		logic [15:0] address;
		logic [7:0]  opcode;
		logic        cb;
		logic        rd;
		logic        wr;
		logic        vv;
		logic [7:0]  value;
	} request_t;

	typedef struct packed {
		logic  hit;
		kind_t kind;
		logic  full;
	} match_result_t;

	typedef struct packed {
		logic [7:0]  value;
		logic        vv;
		logic        wr;
		logic        rd;
		logic [15:0] address;
	} watch_entry_t;

	typedef struct packed {
		request_t      req;
		logic          typed;
		match_result_t res;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  action = '0;
	logic [15:0] address = '0;
	logic [7:0]  opcode = '0;
	logic        cb_prefix = 1'b0;
	logic        is_read = 1'b0;
	logic        is_write = 1'b0;
	logic        value_valid = 1'b0;
	logic [7:0]  data_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        hit;
	logic [1:0]  hit_kind;
	logic        table_full;

	// Shadow copy of the three breakpoint tables
	logic [15:0]  addr_bp [ADDR_SLOTS];
	logic [8:0]   op_bp [OP_SLOTS];
	watch_entry_t watch_bp [WATCH_SLOTS];
	int           addr_used = 0;
	int           op_used = 0;
	int           watch_used = 0;

	match_result_t pending_results [$];
	script_row_t   script [$];
	int            mode = MODE_STEADY;
	int            failures = 0;

	breakpoint_watchpoint_matcher uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.address     (address),
		.opcode      (opcode),
		.cb_prefix   (cb_prefix),
		.is_read     (is_read),
		.is_write    (is_write),
		.value_valid (value_valid),
		.data_value  (data_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.hit_kind    (hit_kind),
		.table_full  (table_full)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// --- prediction ---------------------------------------------------------

	function automatic logic watch_hits(input watch_entry_t e, input request_t r);
		logic value_ok;
		// value only matters when both the access and the entry carry one
		value_ok = (r.vv && e.vv) ? (r.value == e.value) : 1'b1;
		return (e.address == r.address) && value_ok && ((r.rd && e.rd) || (r.wr && e.wr));
	endfunction

	// Updates the shadow tables and returns the result the block owes for r.
	// Every matching entry counts, not just the first address match.
	function automatic match_result_t predict_match(input request_t r);
		match_result_t res;
		res = '{hit: 1'b0, kind: KIND_NONE, full: 1'b0};
		case (r.act)
		ACT_ADD_ADDR: begin
			if (addr_used < ADDR_SLOTS) begin
				addr_bp[addr_used] = r.address;
				addr_used++;
			end else
				res.full = 1'b1;
		end
		ACT_ADD_OP: begin
			if (op_used < OP_SLOTS) begin
				op_bp[op_used] = {r.cb, r.opcode};
				op_used++;
			end else
				res.full = 1'b1;
		end
		ACT_ADD_MEM: begin
			if (watch_used < WATCH_SLOTS) begin
				watch_bp[watch_used] = '{value: r.value, vv: r.vv, wr: r.wr, rd: r.rd,
					address: r.address};
				watch_used++;
			end else
				res.full = 1'b1;
		end
		ACT_CHK_ADDR: begin
			for (int i = 0; i < addr_used; i++)
				if (addr_bp[i] == r.address)
					res.hit = 1'b1;
			res.kind = res.hit ? KIND_ADDR : KIND_NONE;
		end
		ACT_CHK_OP: begin
			for (int i = 0; i < op_used; i++)
				if (op_bp[i] == {r.cb, r.opcode})
					res.hit = 1'b1;
			res.kind = res.hit ? KIND_OP : KIND_NONE;
		end
		ACT_CHK_MEM: begin
			for (int i = 0; i < watch_used; i++)
				if (watch_hits(watch_bp[i], r))
					res.hit = 1'b1;
			res.kind = res.hit ? KIND_MEM : KIND_NONE;
		end
		default: ;	// reserved codes: nothing changes, all-zero result
		endcase
		return res;
	endfunction

	// --- stimulus -------------------------------------------------------------

	function automatic request_t make_req(input logic [2:0] act, input logic [15:0] addr,
		input logic [7:0] op, input logic cb, input logic rd, input logic wr,
		input logic vv, input logic [7:0] value);
		return '{act: act, address: addr, opcode: op, cb: cb, rd: rd, wr: wr, vv: vv,
			value: value};
	endfunction

	function automatic void row(input request_t req, input logic typed, input logic exp_hit,
		input kind_t exp_kind);
		script_row_t entry;
		entry.req   = req;
		entry.typed = typed;
		entry.res   = '{hit: exp_hit, kind: exp_kind, full: 1'b0};
		script.insert(script.size(), entry);
	endfunction

	// Random request. Most checks reuse stored entries so hits are common;
	// the rest is noise. Adds sometimes repeat a watch address so several
	// entries can match one access.
	function automatic request_t draw_request();
		request_t req;
		int pick;
		watch_entry_t e;
		req = make_req(ACT_CHK_ADDR, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)),
			1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
			1'($urandom_range(1)), 8'($urandom_range(255)));
		pick = $urandom_range(99);
		if (pick < 5)
			req.act = $urandom_range(1) ? ACT_RSVD6 : ACT_RSVD7;
		else if (pick < 10)
			req.act = ACT_ADD_ADDR;
		else if (pick < 15)
			req.act = ACT_ADD_OP;
		else if (pick < 20) begin
			req.act = ACT_ADD_MEM;
			if (watch_used > 0 && $urandom_range(99) < 40)
				req.address = watch_bp[$urandom_range(watch_used - 1)].address;
		end else if (pick < 46) begin
			req.act = ACT_CHK_ADDR;
			if (addr_used > 0 && $urandom_range(99) < 65)
				req.address = addr_bp[$urandom_range(addr_used - 1)];
		end else if (pick < 72) begin
			req.act = ACT_CHK_OP;
			if (op_used > 0 && $urandom_range(99) < 65)
				{req.cb, req.opcode} = op_bp[$urandom_range(op_used - 1)];
		end else begin
			req.act = ACT_CHK_MEM;
			if (watch_used > 0 && $urandom_range(99) < 65) begin
				e = watch_bp[$urandom_range(watch_used - 1)];
				req.address = e.address;
				if ($urandom_range(1))
					req.value = e.value;
			end
		end
		return req;
	endfunction

	function automatic logic gap_now();
		if (mode == MODE_SEND_GAPS)
			return $urandom_range(99) < 59;
		if (mode == MODE_BOTH)
			return $urandom_range(99) < 7;
		return 1'b0;
	endfunction

	function automatic logic stall_now();
		if (mode == MODE_RECV_STALLS)
			return $urandom_range(99) < 59;
		if (mode == MODE_BOTH)
			return $urandom_range(99) < 7;
		return 1'b0;
	endfunction

	// Present one request, hold it until accepted, then queue its result.
	// Typed rows queue the hand-written result; the predictor still runs so
	// the shadow tables stay in step.
	task automatic issue_request(input request_t req, input logic typed,
		input match_result_t typed_res);
		match_result_t res;
		while (gap_now()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= req.act;
		address     <= req.address;
		opcode      <= req.opcode;
		cb_prefix   <= req.cb;
		is_read     <= req.rd;
		is_write    <= req.wr;
		value_valid <= req.vv;
		data_value  <= req.value;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		res = predict_match(req);
		pending_results.insert(pending_results.size(), typed ? typed_res : res);
	endtask

	// --- result side ------------------------------------------------------------

	always @(posedge clk) begin
		match_result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: hit %0d kind %0d full %0d",
					hit, hit_kind, table_full);
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					failures++;
				end
				if (hit_kind !== want.kind) begin
					$error("hit_kind: expected %0d, got %0d", want.kind, hit_kind);
					failures++;
				end
				if (table_full !== want.full) begin
					$error("table_full: expected %0d, got %0d", want.full, table_full);
					failures++;
				end
			end
		end
		out_ready <= !stall_now();
	end

	// --- sequence -----------------------------------------------------------------

	initial begin
		// empty tables and reserved codes: everything reads zero
		row(make_req(ACT_CHK_ADDR, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
			TYPED, 1'b0, KIND_NONE);
		row(make_req(ACT_CHK_OP, 16'hFFFF, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 8'hFF),
			TYPED, 1'b0, KIND_NONE);
		row(make_req(ACT_CHK_MEM, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 8'hFF),
			TYPED, 1'b0, KIND_NONE);
		row(make_req(ACT_RSVD6, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF),
			TYPED, 1'b0, KIND_NONE);
		row(make_req(ACT_RSVD7, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
			TYPED, 1'b0, KIND_NONE);
		// adds at the field extremes
		row(make_req(ACT_ADD_ADDR, 16'h0000, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF),
			TYPED, 1'b0, KIND_NONE);
		row(make_req(ACT_ADD_ADDR, 16'hFFFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
			TYPED, 1'b0, KIND_NONE);
		row(make_req(ACT_ADD_OP, 16'hFFFF, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 8'hFF),
			TYPED, 1'b0, KIND_NONE);
		row(make_req(ACT_ADD_OP, 16'h0000, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00),
			TYPED, 1'b0, KIND_NONE);
		// read watch with value, write watch without
		row(make_req(ACT_ADD_MEM, 16'hFFFF, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 8'hFF),
			TYPED, 1'b0, KIND_NONE);
		row(make_req(ACT_ADD_MEM, 16'h0000, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00),
			TYPED, 1'b0, KIND_NONE);
		// plain hits, and a miss on an address not stored
		row(make_req(ACT_CHK_ADDR, 16'hFFFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
			TYPED, 1'b1, KIND_ADDR);
		row(make_req(ACT_CHK_ADDR, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
			TYPED, 1'b1, KIND_ADDR);
		row(make_req(ACT_CHK_ADDR, 16'h1234, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
			PREDICT, 1'b0, KIND_NONE);
		row(make_req(ACT_CHK_OP, 16'h0000, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00),
			TYPED, 1'b1, KIND_OP);
		// same opcode, wrong prefix set
		row(make_req(ACT_CHK_OP, 16'h0000, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
			PREDICT, 1'b0, KIND_NONE);
		row(make_req(ACT_CHK_OP, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
			TYPED, 1'b1, KIND_OP);
		row(make_req(ACT_CHK_MEM, 16'hFFFF, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 8'hFF),
			TYPED, 1'b1, KIND_MEM);
		// value mismatch when both sides carry a value
		row(make_req(ACT_CHK_MEM, 16'hFFFF, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 8'hFE),
			PREDICT, 1'b0, KIND_NONE);
		// access without a value ignores the entry's value
		row(make_req(ACT_CHK_MEM, 16'hFFFF, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 8'h12),
			PREDICT, 1'b0, KIND_NONE);
		// wrong direction
		row(make_req(ACT_CHK_MEM, 16'hFFFF, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'hFF),
			PREDICT, 1'b0, KIND_NONE);
		// entry without a value ignores the access value
		row(make_req(ACT_CHK_MEM, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'h55),
			PREDICT, 1'b0, KIND_NONE);
		row(make_req(ACT_CHK_MEM, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00),
			PREDICT, 1'b0, KIND_NONE);
		row(make_req(ACT_CHK_MEM, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00),
			PREDICT, 1'b0, KIND_NONE);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			issue_request(script[i].req, script[i].typed, script[i].res);

		// random traffic under each pressure mode; tables fill early and
		// later adds exercise the dropped-add flag
		for (int m = 0; m < MODE_COUNT; m++) begin
			mode = m;
			for (int n = 0; n < REQS_PER_MODE; n++)
				issue_request(draw_request(), PREDICT, '0);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#(12 * 600000);
		$display("FAIL");
		$finish;
	end

endmodule
